>>> src/sfc_pkg.sv
// shared types, constants and the crc step for the stuffed response frame checker
// no dependencies
`default_nettype none

package sfc_pkg;

  // framing characters and expected header
  localparam logic [7:0]  StartChar     = 8'h2B;
  localparam logic [7:0]  EscapeChar    = 8'h2D;
  localparam logic [7:0]  CmdResponse   = 8'd5;
  localparam logic [7:0]  LenResponse   = 8'd8;
  localparam logic [31:0] BootSignature = 32'h50F7_05AB;

  // crc-16-ccitt
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // frame layout: bytes 0..11, crc over 0..9
  localparam int unsigned FrameLen = 12;
  localparam int unsigned CrcLen   = 10;
  localparam int unsigned CntW     = 4;
  // bytes 2..11 kept in a shift line
  localparam int unsigned TailBytes = FrameLen - 2;

  // configuration register indexes
  typedef enum logic {
    REG_LISTENING   = 1'b0,
    REG_EXPECTED_ID = 1'b1
  } cfg_reg_e;

  // result codes
  typedef enum logic [1:0] {
    KIND_SIGNATURE = 2'd0,
    KIND_VALID     = 2'd1,
    KIND_MISMATCH  = 2'd2
  } result_kind_e;

  // event passed from front to back through the queue
  typedef struct packed {
    logic        is_frame;  // matched complete frame
    logic [15:0] crc;       // computed crc over bytes 0..9
    logic [31:0] value;     // bytes 6..9
    logic [15:0] want;      // bytes 10..11
    logic        seen;      // bootloader signature in raw stream
  } sfc_event_t;

  // one byte of crc, msb first, no final xor
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in;
    for (int k = 7; k >= 0; k--) begin
      if (c[15] ^ b[k]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/stuffed_response_frame_checker.sv
// top level of the stuffed response frame checker: front, event queue, back
// depends on sfc_pkg, sfc_front, sfc_queue, sfc_back
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in      | input     | in_valid_i/in_stall_o | rx_byte_i
//   out     | output    | out_valid_o/out_stall_i | result_kind_o, value_bits_o,
//           |           |                      | bootloader_seen_o
//   cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// one byte per cycle while in_stall_o is low; the byte is unstuffed, framed and
// crc-updated in the cycle it is taken, so the front has no per-byte loop longer
// than one unrolled crc step. a result is held in a queue entry and then in the
// output register. in_stall_o rises only while the two-entry queue is full, which
// happens when out_stall_i holds results back. reset is asynchronous, active low,
// and needs no clearing pass.
`default_nettype none

module stuffed_response_frame_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [31:0]      value_bits_o,
  output logic             bootloader_seen_o
);
  import sfc_pkg::*;

  logic        q_full, q_not_empty, q_pop, push;
  logic        in_xfer;
  sfc_event_t  push_data, head;

  // input transfer
  assign in_stall_o = q_full;
  assign in_xfer    = in_valid_i && !q_full;

  sfc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (in_xfer),
    .byte_i       (rx_byte_i),
    .push_o       (push),
    .event_o      (push_data)
  );

  sfc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .pop_i       (q_pop),
    .head_o      (head)
  );

  sfc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (q_not_empty),
    .head_i            (head),
    .pop_o             (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_kind_o     (result_kind_o),
    .value_bits_o      (value_bits_o),
    .bootloader_seen_o (bootloader_seen_o)
  );

endmodule

`default_nettype wire

>>> src/sfc_front.sv
// front part: unstuffs raw bytes, tracks the frame, runs the crc, holds config
// depends on sfc_pkg
`default_nettype none

module sfc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               byte_valid_i,
  input  wire logic [7:0]         byte_i,
  output logic                    push_o,
  output sfc_pkg::sfc_event_t     event_o
);
  import sfc_pkg::*;

  logic                     listening_q, listening_d;
  logic [31:0]              expected_id_q, expected_id_d;
  logic [7:0]               prev_q, prev_d;
  logic                     awaiting_q, awaiting_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [31:0]              sig_q, sig_d;
  logic [15:0]              crc_q, crc_d;
  logic [8*TailBytes-1:0]   tail_q, tail_d;

  logic                     store;
  logic                     seen;
  logic                     is_plus, is_esc, prev_esc;
  logic [8*TailBytes-1:0]   full;
  logic                     frame_match;
  logic [15:0]              crc_base;

  assign is_plus  = (byte_i == StartChar);
  assign is_esc   = (byte_i == EscapeChar);
  assign prev_esc = (prev_q == EscapeChar);
  assign full     = {tail_q[8*TailBytes-9:0], byte_i};
  assign crc_base = (count_q == '0) ? CrcInit : crc_q;

  // per byte frame tracking
  always_comb begin
    listening_d   = listening_q;
    expected_id_d = expected_id_q;
    prev_d        = prev_q;
    awaiting_d    = awaiting_q;
    count_d       = count_q;
    sig_d         = sig_q;
    crc_d         = crc_q;
    tail_d        = tail_q;
    store         = 1'b0;
    seen          = 1'b0;
    frame_match   = 1'b0;

    if (byte_valid_i) begin
      sig_d  = {sig_q[23:0], byte_i};
      seen   = (sig_d == BootSignature);
      prev_d = byte_i;

      // unstuffing
      if (awaiting_q) begin
        if (is_plus && !prev_esc) begin
          awaiting_d = 1'b0;
        end
      end else if (is_plus) begin
        if (prev_esc) begin
          store = 1'b1;
        end else begin
          count_d = '0;
        end
      end else if (is_esc) begin
        store = prev_esc;
      end else begin
        store = 1'b1;
      end

      // store the byte, advance the crc over bytes 0..9
      if (store) begin
        count_d = count_q + 1'b1;
        tail_d  = full;
        if (count_q < CntW'(CrcLen)) begin
          crc_d = crc_byte(crc_base, byte_i);
        end
      end

      // header checks and frame completion
      if (store && count_q == CntW'(0) && byte_i != CmdResponse) begin
        awaiting_d = 1'b1;
        count_d    = '0;
      end else if (store && count_q == CntW'(1) && byte_i != LenResponse) begin
        awaiting_d = 1'b1;
        count_d    = '0;
      end else if (store && count_q == CntW'(FrameLen - 1)) begin
        if (listening_q && full[79:48] == expected_id_q) begin
          frame_match = 1'b1;
          listening_d = 1'b0;
        end
        awaiting_d = 1'b1;
        count_d    = '0;
      end
    end

    // configuration writes
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LISTENING:   listening_d   = cfg_wdata_i[0];
        REG_EXPECTED_ID: expected_id_d = cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // event to the queue
  assign push_o            = frame_match || seen;
  assign event_o.is_frame  = frame_match;
  assign event_o.crc       = crc_q;
  assign event_o.value     = full[47:16];
  assign event_o.want      = full[15:0];
  assign event_o.seen      = seen;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listening_q   <= 1'b0;
      expected_id_q <= '0;
      prev_q        <= '0;
      awaiting_q    <= 1'b1;
      count_q       <= '0;
      sig_q         <= '0;
    end else begin
      listening_q   <= listening_d;
      expected_id_q <= expected_id_d;
      prev_q        <= prev_d;
      awaiting_q    <= awaiting_d;
      count_q       <= count_d;
      sig_q         <= sig_d;
    end
  end

  // frame payload, always written before read
  always_ff @(posedge clk_i) begin
    crc_q  <= crc_d;
    tail_q <= tail_d;
  end

endmodule

`default_nettype wire

>>> src/sfc_queue.sv
// two-entry event queue between front and back
// depends on sfc_pkg
`default_nettype none

module sfc_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire sfc_pkg::sfc_event_t push_data_i,
  output logic                    full_o,
  output logic                    not_empty_o,
  input  wire logic               pop_i,
  output sfc_pkg::sfc_event_t     head_o
);
  import sfc_pkg::*;

  sfc_event_t  mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        do_push, do_pop;

  assign full_o      = (count_q == 2'd2);
  assign not_empty_o = (count_q != 2'd0);
  assign head_o      = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/sfc_back.sv
// back part: checks the crc, forms the result and holds it in the output register
// depends on sfc_pkg
`default_nettype none

module sfc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  wire sfc_pkg::sfc_event_t head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              result_kind_o,
  output logic [31:0]             value_bits_o,
  output logic                    bootloader_seen_o
);
  import sfc_pkg::*;

  logic          valid_q;
  result_kind_e  kind_q, kind_d;
  logic [31:0]   value_q, value_d;
  logic          seen_q;
  logic          load;

  // take a new event when the output register is free or being taken
  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && head_valid_i;

  // result formation
  always_comb begin
    kind_d  = KIND_SIGNATURE;
    value_d = '0;
    if (head_i.is_frame) begin
      if (head_i.crc == head_i.want) begin
        kind_d  = KIND_VALID;
        value_d = head_i.value;
      end else begin
        kind_d  = KIND_MISMATCH;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= head_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      seen_q  <= head_i.seen;
    end
  end

  assign out_valid_o       = valid_q;
  assign result_kind_o     = kind_q;
  assign value_bits_o      = value_q;
  assign bootloader_seen_o = seen_q;

endmodule

`default_nettype wire

>>> test/stuffed_response_frame_checker_tb.sv
// testbench for stuffed_response_frame_checker: self-checking, byte stream in, results out
// depends on sfc_pkg and the stuffed_response_frame_checker rtl
module stuffed_response_frame_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfc_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongHold      = 40;

  // one result as the block should report it
  typedef struct packed {
    result_kind_e kind;
    logic [31:0]  value;
    logic         seen;
  } rx_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  cfg_reg_e         cfg_idx = REG_LISTENING;
  logic [31:0]      cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic [7:0]       rx_byte = '0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [1:0]       result_kind;
  logic [31:0]      value_bits;
  logic             bootloader_seen;

  // bytes waiting to be sent and results waiting to arrive
  logic [7:0]       tx_bytes[$];
  rx_result_t       reports_due[$];

  // shadow of the block: registers and frame state
  logic             listen_q;
  logic [31:0]      want_id;
  logic [7:0]       last_raw;
  logic             hunting;
  int unsigned      stored;
  logic [7:0]       frame_bytes[FrameLen];
  logic [31:0]      sig_window;

  int unsigned      bytes_queued;
  int unsigned      results_checked;
  int unsigned      mismatches;
  int unsigned      quiet_cycles;
  logic             no_idle = 1'b0;
  logic             long_hold_req = 1'b0;
  logic             long_hold_done;
  int unsigned      gap_left;
  int unsigned      stall_left;
  int unsigned      hold_left;

  stuffed_response_frame_checker u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .result_kind_o    (result_kind),
    .value_bits_o     (value_bits),
    .bootloader_seen_o(bootloader_seen)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // crc-16-ccitt, msb first, one byte folded into the top then shifted out
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] frame_crc(input logic [7:0] cmd, input logic [7:0] len,
                                            input logic [31:0] id, input logic [31:0] value);
    logic [15:0] c;
    logic [79:0] body;
    c = CrcInit;
    body = {cmd, len, id, value};
    for (int i = 9; i >= 0; i--) begin
      c = crc_update(c, body[i*8 +: 8]);
    end
    return c;
  endfunction

  // random byte, biased toward the framing characters and the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return StartChar;
      1: return EscapeChar;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
  endfunction

  task automatic keep_byte(input logic [7:0] b);
    if (stored < FrameLen) begin
      frame_bytes[stored] = b;
      stored++;
    end
  endtask

  // advance the shadow by one accepted byte and queue what it should report
  task automatic track_rx_byte(input logic [7:0] b);
    rx_result_t  r;
    logic        got;
    logic [31:0] id_field;
    logic [15:0] crc;
    got = 1'b0;
    r.kind = KIND_SIGNATURE;
    r.value = '0;
    sig_window = {sig_window[23:0], b};
    r.seen = (sig_window == BootSignature);
    // unstuffing; the escape test looks at the previous raw byte
    if (hunting) begin
      if (b == StartChar && last_raw != EscapeChar) hunting = 1'b0;
    end else if (b == StartChar) begin
      if (last_raw == EscapeChar) keep_byte(b);
      else stored = 0;
    end else if (b == EscapeChar) begin
      if (last_raw == EscapeChar) keep_byte(b);
    end else begin
      keep_byte(b);
    end
    last_raw = b;
    // header checks and frame completion
    if (stored == 1 && frame_bytes[0] != CmdResponse) begin
      hunting = 1'b1;
      stored = 0;
    end else if (stored == 2 && frame_bytes[1] != LenResponse) begin
      hunting = 1'b1;
      stored = 0;
    end else if (stored >= FrameLen) begin
      id_field = {frame_bytes[2], frame_bytes[3], frame_bytes[4], frame_bytes[5]};
      if (listen_q && id_field == want_id) begin
        crc = CrcInit;
        for (int i = 0; i < CrcLen; i++) crc = crc_update(crc, frame_bytes[i]);
        got = 1'b1;
        if (crc != {frame_bytes[10], frame_bytes[11]}) begin
          r.kind = KIND_MISMATCH;
        end else begin
          r.kind = KIND_VALID;
          r.value = {frame_bytes[6], frame_bytes[7], frame_bytes[8], frame_bytes[9]};
        end
        listen_q = 1'b0;
      end
      hunting = 1'b1;
      stored = 0;
    end
    if (got || r.seen) reports_due.push_back(r);
  endtask

  // stimulus helpers
  task automatic push_raw(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_stuffed(input logic [7:0] b);
    if (b == StartChar || b == EscapeChar) push_raw(EscapeChar);
    push_raw(b);
  endtask

  task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] len,
                             input logic [31:0] id, input logic [31:0] value,
                             input logic [15:0] crc);
    logic [95:0] body;
    body = {cmd, len, id, value, crc};
    push_raw(StartChar);
    for (int i = 11; i >= 0; i--) push_stuffed(body[i*8 +: 8]);
  endtask

  task automatic queue_signature();
    for (int i = 3; i >= 0; i--) push_raw(BootSignature[i*8 +: 8]);
  endtask

  // wait until every byte is sent and every result is back, then let the block settle
  task automatic wait_drained(input int unsigned settle);
    while (tx_bytes.size() != 0 || in_valid || reports_due.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // register writes, only while the block is idle
  task automatic start_phase(input logic listen, input logic [31:0] id);
    logic [31:0] word;
    wait_drained(6);
    word = $urandom();
    word[0] = listen;
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= REG_LISTENING;
    cfg_wdata <= word;
    listen_q = listen;
    @(posedge clk_i);
    cfg_idx <= REG_EXPECTED_ID;
    cfg_wdata <= id;
    want_id = id;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // driver: feeds tx_bytes, with random gaps between transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      rx_byte <= '0;
      gap_left = 0;
      listen_q = 1'b0;
      want_id = '0;
      last_raw = '0;
      hunting = 1'b1;
      stored = 0;
      sig_window = '0;
    end else begin
      if (in_valid && !in_stall) track_rx_byte(rx_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left == 0 && !no_idle && $urandom_range(0, 6) == 0) begin
          gap_left = $urandom_range(1, 5);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() > 0) begin
          in_valid <= 1'b1;
          rx_byte <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer and drives the output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result: kind %0d value %08h seen %0b", $realtime,
                     result_kind, value_bits, bootloader_seen);
          end
        end else begin
          rx_result_t exp_r;
          exp_r = reports_due.pop_front();
          results_checked++;
          if (result_kind !== exp_r.kind || value_bits !== exp_r.value ||
              bootloader_seen !== exp_r.seen) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch (exp/act): kind %0d/%0d value %08h/%08h seen %0b/%0b",
                       $realtime, exp_r.kind, result_kind, exp_r.value, value_bits,
                       exp_r.seen, bootloader_seen);
            end
          end
        end
      end
      // one long hold-off to back the block up, plus short random bursts
      if (long_hold_req && !long_hold_done) begin
        hold_left = LongHold;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned frames;
    int unsigned pick;
    logic        listen;
    logic [31:0] id;
    logic [31:0] value;
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [15:0] crc;
    bytes_queued = 0;
    results_checked = 0;
    mismatches = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: signature alone, escaped start while hunting, clean valid frame
    start_phase(1'b1, 32'hFFFF_FFFF);
    queue_signature();
    push_raw(EscapeChar);
    push_raw(EscapeChar);
    push_raw(StartChar);
    queue_frame(CmdResponse, LenResponse, 32'hFFFF_FFFF, 32'h00FF_8001,
                frame_crc(CmdResponse, LenResponse, 32'hFFFF_FFFF, 32'h00FF_8001));
    // directed: frame whose raw tail is the signature, with a wrong checksum
    start_phase(1'b1, 32'h0000_0000);
    queue_frame(CmdResponse, LenResponse, 32'h0000_0000, 32'h002B_50F7, 16'h05AB);

    // random phases of noise, frames and signatures
    phase = 0;
    while (bytes_queued < 750) begin
      if (bytes_queued > 650) no_idle = 1'b1;
      listen = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 5))
        0: id = 32'h0000_0000;
        1: id = 32'hFFFF_FFFF;
        2: id = {StartChar, EscapeChar, StartChar, EscapeChar};
        default: id = $urandom();
      endcase
      if (phase == 6) begin
        // receiver holds off while a run of signatures piles up results
        start_phase(1'b0, id);
        long_hold_req = 1'b1;
        repeat (12) queue_signature();
      end else begin
        start_phase(listen, id);
      end
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        repeat ($urandom_range(0, 3)) push_raw(pick_byte());
        cmd = CmdResponse;
        len = LenResponse;
        value = pick_word();
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          cmd = pick_byte();
          if (cmd == CmdResponse) cmd = ~cmd;
        end else if (pick == 1) begin
          len = pick_byte();
          if (len == LenResponse) len = ~len;
        end
        if (pick == 2) begin
          // cut short; the next start restarts the count
          push_raw(StartChar);
          push_stuffed(CmdResponse);
          push_stuffed(LenResponse);
          repeat ($urandom_range(0, 8)) push_stuffed(pick_byte());
        end else begin
          if (pick == 3) id = pick_word();
          crc = frame_crc(cmd, len, id, value);
          if ($urandom_range(0, 4) == 0) crc = crc ^ 16'($urandom_range(1, 65535));
          queue_frame(cmd, len, id, value, crc);
        end
      end
      if ($urandom_range(0, 2) == 0) queue_signature();
      phase++;
    end

    wait_drained(10);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
src/sfc_pkg.sv
src/sfc_front.sv
src/sfc_queue.sv
src/sfc_back.sv
src/stuffed_response_frame_checker.sv
test/stuffed_response_frame_checker_tb.sv
